// ===== rtl/core/gbdc_pkg.sv =====
// ----------------------------------------------------------------------------
// gbdc_pkg
// Shared types and constants of the gyro bias dead band calibrator.
// ----------------------------------------------------------------------------
`default_nettype none

package gbdc_pkg;

  localparam int unsigned RawW    = 16;
  localparam int unsigned RateW   = 21;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  localparam logic [CfgIdxW-1:0] CfgRateScale = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCalibCount = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgThreshold = 2'd2;

  localparam logic [15:0] RateScaleRst  = 16'd500;
  localparam logic [7:0]  CalibCountRst = 8'd50;
  localparam logic [7:0]  ThresholdRst  = 8'd0;

  localparam logic CmdMeasure   = 1'b0;
  localparam logic CmdCalibrate = 1'b1;

  localparam logic [1:0] LastAxis = 2'd2;
  localparam logic [4:0] LastStep = 5'd31;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAS1,
    ST_MEAS2,
    ST_CAL1,
    ST_CAL2,
    ST_FMUL1,
    ST_FMUL2,
    ST_FSQ_INIT,
    ST_FSQ,
    ST_FDEV_INIT,
    ST_FDEV,
    ST_FOFF_INIT,
    ST_FOFF,
    ST_FSTORE,
    ST_EMIT
  } gbdc_state_e;

  typedef struct packed {
    logic       load_in;
    logic       meas_mul;
    logic       meas_fin;
    logic       cal_sq;
    logic       cal_acc;
    logic       fin_mul1;
    logic       fin_mul2;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init_dev;
    logic       div_init_off;
    logic       div_step;
    logic       store_dev;
    logic       store_off;
    logic       load_out;
    logic [1:0] axis;
  } gbdc_cmd_t;

  typedef struct packed {
    logic run_full;
  } gbdc_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/gbdc_if.sv =====
// ----------------------------------------------------------------------------
// gbdc interfaces
// Sample, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbdc_in_if;
  logic              valid;
  logic              ready;
  logic              command;
  logic signed [15:0] raw_x;
  logic signed [15:0] raw_y;
  logic signed [15:0] raw_z;
  modport source (output valid, command, raw_x, raw_y, raw_z, input ready);
  modport sink (input valid, command, raw_x, raw_y, raw_z, output ready);
endinterface

interface gbdc_out_if;
  logic              valid;
  logic              ready;
  logic signed [20:0] rate_x;
  logic signed [20:0] rate_y;
  logic signed [20:0] rate_z;
  logic              is_calibrated;
  logic              calib_done;
  modport source (output valid, rate_x, rate_y, rate_z, is_calibrated, calib_done,
                  input ready);
  modport sink (input valid, rate_x, rate_y, rate_z, is_calibrated, calib_done,
                output ready);
endinterface

interface gbdc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gbdc_datapath.sv =====
// ----------------------------------------------------------------------------
// gbdc_datapath
// Config registers, accumulators, measure lanes, shared sqrt and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module gbdc_datapath (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire gbdc_pkg::gbdc_cmd_t       cmd_i,
  output      gbdc_pkg::gbdc_sts_t       sts_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [1:0]                cfg_idx_i,
  input  wire logic [15:0]               cfg_data_i,
  input  wire logic signed [15:0]        raw_x_i,
  input  wire logic signed [15:0]        raw_y_i,
  input  wire logic signed [15:0]        raw_z_i,
  output      logic signed [20:0]        rate_x_o,
  output      logic signed [20:0]        rate_y_o,
  output      logic signed [20:0]        rate_z_o,
  output      logic                      is_calibrated_o,
  output      logic                      calib_done_o
);

  logic [15:0] scale_q;
  logic [7:0]  ccount_q;
  logic [7:0]  thr_q;

  logic signed [15:0] raw_q [3];
  logic signed [24:0] sum_q [3];
  logic [38:0]        sumsq_q [3];
  logic [7:0]         cnt_q;
  logic signed [19:0] off_q [3];
  logic [23:0]        dev_q [3];
  logic               flag_q;

  logic [30:0]        sq_q [3];
  logic signed [38:0] prod_q [3];
  logic [31:0]        band_q [3];
  logic signed [20:0] rate_q [3];
  logic               done_q;

  logic [46:0] p1_q;
  logic [46:0] p2_q;
  logic [62:0] sx_q;
  logic [62:0] sres_q;
  logic [62:0] sbit_q;
  logic [31:0] dq_q;
  logic [7:0]  rem_q;
  logic        neg_q;

  logic signed [20:0] out_rate_q [3];
  logic               out_cal_q;
  logic               out_done_q;

  // run completion check
  logic [7:0] target;
  assign target = (ccount_q == 8'd0) ? 8'd1 : ccount_q;
  assign sts_o.run_full = (({1'b0, cnt_q} + 9'd1) >= {1'b0, target});

  // measure lanes
  logic signed [21:0] d_w     [3];
  logic signed [38:0] mul_w   [3];
  logic [31:0]        bmul_w  [3];
  logic signed [38:0] adj_w   [3];
  logic signed [26:0] r_w     [3];
  logic [26:0]        mag_w   [3];
  logic               zero_w  [3];
  logic signed [20:0] sat_w   [3];
  logic signed [31:0] sqm_w   [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    always_comb begin
      d_w[i] = {{2{raw_q[i][15]}}, raw_q[i], 4'b0000};
      if (flag_q) begin
        d_w[i] = d_w[i] - {{2{off_q[i][19]}}, off_q[i]};
      end
      mul_w[i]  = 39'(d_w[i]) * 39'($signed({1'b0, scale_q}));
      bmul_w[i] = {8'd0, dev_q[i]} * {24'd0, thr_q};
      sqm_w[i]  = raw_q[i] * raw_q[i];
      // truncate toward zero
      adj_w[i] = prod_q[i] + (prod_q[i][38] ? 39'sd4095 : 39'sd0);
      r_w[i]   = adj_w[i][38:12];
      mag_w[i] = r_w[i][26] ? 27'(-r_w[i]) : 27'(r_w[i]);
      zero_w[i] = (thr_q != 8'd0) &&
                  ({5'b0, mag_w[i][26:8], 8'b0} < band_q[i]);
      if (zero_w[i]) begin
        sat_w[i] = '0;
      end else if (r_w[i] > 27'sd1048575) begin
        sat_w[i] = 21'sd1048575;
      end else if (r_w[i] < -27'sd1048576) begin
        sat_w[i] = -21'sd1048576;
      end else begin
        sat_w[i] = r_w[i][20:0];
      end
    end
  end

  // finish arithmetic for the selected axis
  logic signed [24:0] s_sel;
  logic signed [49:0] ss_w;
  logic signed [47:0] v_w;
  logic [46:0]        vpos_w;
  logic [63:0]        ssum_w;
  logic [28:0]        a_w;
  logic [28:0]        amag_w;
  logic [8:0]         r2_w;
  logic               ge_w;
  logic [31:0]        qa_w;

  always_comb begin
    s_sel  = sum_q[cmd_i.axis];
    ss_w   = s_sel * s_sel;
    v_w    = $signed({1'b0, p1_q}) - $signed({1'b0, p2_q});
    vpos_w = v_w[47] ? 47'd0 : v_w[46:0];
    ssum_w = {1'b0, sres_q} + {1'b0, sbit_q};
    a_w    = {s_sel, 4'b0000};
    amag_w = s_sel[24] ? 29'(-a_w) : a_w;
    r2_w   = {rem_q, dq_q[31]};
    ge_w   = (r2_w >= {1'b0, cnt_q});
    qa_w   = dq_q + {31'd0, (rem_q != 8'd0)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= gbdc_pkg::RateScaleRst;
      ccount_q <= gbdc_pkg::CalibCountRst;
      thr_q    <= gbdc_pkg::ThresholdRst;
      cnt_q    <= '0;
      flag_q   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_q[i]   <= '0;
        sumsq_q[i] <= '0;
        off_q[i]   <= '0;
        dev_q[i]   <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          gbdc_pkg::CfgRateScale:  scale_q  <= cfg_data_i;
          gbdc_pkg::CfgCalibCount: ccount_q <= cfg_data_i[7:0];
          gbdc_pkg::CfgThreshold:  thr_q    <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (cmd_i.cal_acc) begin
        for (int i = 0; i < 3; i++) begin
          sum_q[i]   <= sum_q[i] + 25'(raw_q[i]);
          sumsq_q[i] <= sumsq_q[i] + {8'd0, sq_q[i]};
        end
        cnt_q <= cnt_q + 8'd1;
      end
      if (cmd_i.store_dev) begin
        dev_q[cmd_i.axis] <= dq_q[23:0];
      end
      if (cmd_i.store_off) begin
        // round the magnitude up for a negative mean so the offset floors
        off_q[cmd_i.axis] <= neg_q ? 20'(-qa_w) : dq_q[19:0];
        if (cmd_i.axis == gbdc_pkg::LastAxis) begin
          for (int i = 0; i < 3; i++) begin
            sum_q[i]   <= '0;
            sumsq_q[i] <= '0;
          end
          cnt_q  <= '0;
          flag_q <= 1'b1;
        end
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      raw_q[0] <= raw_x_i;
      raw_q[1] <= raw_y_i;
      raw_q[2] <= raw_z_i;
    end
    for (int i = 0; i < 3; i++) begin
      if (cmd_i.meas_mul) begin
        prod_q[i] <= mul_w[i];
        band_q[i] <= bmul_w[i];
      end
      if (cmd_i.meas_fin) rate_q[i] <= sat_w[i];
      if (cmd_i.cal_sq)   sq_q[i]   <= sqm_w[i][30:0];
      if (cmd_i.cal_acc)  rate_q[i] <= '0;
    end
    if (cmd_i.meas_fin) done_q <= 1'b0;
    if (cmd_i.cal_acc)  done_q <= sts_o.run_full;
    if (cmd_i.fin_mul1) p1_q <= {39'd0, cnt_q} * {8'd0, sumsq_q[cmd_i.axis]};
    if (cmd_i.fin_mul2) p2_q <= ss_w[46:0];
    if (cmd_i.sqrt_init) begin
      sx_q   <= {vpos_w, 16'd0};
      sres_q <= '0;
      sbit_q <= {1'b1, 62'd0};
    end else if (cmd_i.sqrt_step) begin
      if ({1'b0, sx_q} >= ssum_w) begin
        sx_q   <= sx_q - ssum_w[62:0];
        sres_q <= (sres_q >> 1) + sbit_q;
      end else begin
        sres_q <= sres_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
    if (cmd_i.div_init_dev) begin
      dq_q  <= sres_q[31:0];
      rem_q <= '0;
    end else if (cmd_i.div_init_off) begin
      dq_q  <= {3'd0, amag_w};
      rem_q <= '0;
      neg_q <= s_sel[24];
    end else if (cmd_i.div_step) begin
      rem_q <= ge_w ? 8'(r2_w - {1'b0, cnt_q}) : r2_w[7:0];
      dq_q  <= {dq_q[30:0], ge_w};
    end
    if (cmd_i.load_out) begin
      out_rate_q <= rate_q;
      out_cal_q  <= flag_q;
      out_done_q <= done_q;
    end
  end

  assign rate_x_o        = out_rate_q[0];
  assign rate_y_o        = out_rate_q[1];
  assign rate_z_o        = out_rate_q[2];
  assign is_calibrated_o = out_cal_q;
  assign calib_done_o    = out_done_q;

endmodule

`default_nettype wire

// ===== rtl/core/gbdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbdc_ctrl
// Sequencer: measure and calibrate steps, per-axis finish loop, result slot.
// ----------------------------------------------------------------------------
`default_nettype none

module gbdc_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_command_i,
  output      logic                in_ready_o,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      gbdc_pkg::gbdc_cmd_t cmd_o,
  input  wire gbdc_pkg::gbdc_sts_t sts_i
);

  gbdc_pkg::gbdc_state_e state_q, state_d;
  logic [1:0] axis_q;
  logic [4:0] step_q;
  logic       out_valid_q;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gbdc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_command_i == gbdc_pkg::CmdCalibrate) ?
                    gbdc_pkg::ST_CAL1 : gbdc_pkg::ST_MEAS1;
        end
      end
      gbdc_pkg::ST_MEAS1:     state_d = gbdc_pkg::ST_MEAS2;
      gbdc_pkg::ST_MEAS2:     state_d = gbdc_pkg::ST_EMIT;
      gbdc_pkg::ST_CAL1:      state_d = gbdc_pkg::ST_CAL2;
      gbdc_pkg::ST_CAL2: begin
        state_d = sts_i.run_full ? gbdc_pkg::ST_FMUL1 : gbdc_pkg::ST_EMIT;
      end
      gbdc_pkg::ST_FMUL1:     state_d = gbdc_pkg::ST_FMUL2;
      gbdc_pkg::ST_FMUL2:     state_d = gbdc_pkg::ST_FSQ_INIT;
      gbdc_pkg::ST_FSQ_INIT:  state_d = gbdc_pkg::ST_FSQ;
      gbdc_pkg::ST_FSQ: begin
        if (step_q == gbdc_pkg::LastStep) state_d = gbdc_pkg::ST_FDEV_INIT;
      end
      gbdc_pkg::ST_FDEV_INIT: state_d = gbdc_pkg::ST_FDEV;
      gbdc_pkg::ST_FDEV: begin
        if (step_q == gbdc_pkg::LastStep) state_d = gbdc_pkg::ST_FOFF_INIT;
      end
      gbdc_pkg::ST_FOFF_INIT: state_d = gbdc_pkg::ST_FOFF;
      gbdc_pkg::ST_FOFF: begin
        if (step_q == gbdc_pkg::LastStep) state_d = gbdc_pkg::ST_FSTORE;
      end
      gbdc_pkg::ST_FSTORE: begin
        state_d = (axis_q == gbdc_pkg::LastAxis) ? gbdc_pkg::ST_EMIT : gbdc_pkg::ST_FMUL1;
      end
      gbdc_pkg::ST_EMIT: begin
        if (slot_free) state_d = gbdc_pkg::ST_IDLE;
      end
      default: state_d = gbdc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.axis = axis_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      gbdc_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      gbdc_pkg::ST_MEAS1:     cmd_o.meas_mul     = 1'b1;
      gbdc_pkg::ST_MEAS2:     cmd_o.meas_fin     = 1'b1;
      gbdc_pkg::ST_CAL1:      cmd_o.cal_sq       = 1'b1;
      gbdc_pkg::ST_CAL2:      cmd_o.cal_acc      = 1'b1;
      gbdc_pkg::ST_FMUL1:     cmd_o.fin_mul1     = 1'b1;
      gbdc_pkg::ST_FMUL2:     cmd_o.fin_mul2     = 1'b1;
      gbdc_pkg::ST_FSQ_INIT:  cmd_o.sqrt_init    = 1'b1;
      gbdc_pkg::ST_FSQ:       cmd_o.sqrt_step    = 1'b1;
      gbdc_pkg::ST_FDEV_INIT: cmd_o.div_init_dev = 1'b1;
      gbdc_pkg::ST_FDEV: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.store_dev = 1'b0;
      end
      gbdc_pkg::ST_FOFF_INIT: begin
        cmd_o.store_dev    = 1'b1;
        cmd_o.div_init_off = 1'b1;
      end
      gbdc_pkg::ST_FOFF:      cmd_o.div_step     = 1'b1;
      gbdc_pkg::ST_FSTORE:    cmd_o.store_off    = 1'b1;
      gbdc_pkg::ST_EMIT:      cmd_o.load_out     = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gbdc_pkg::ST_IDLE;
      axis_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == gbdc_pkg::ST_CAL2) axis_q <= '0;
      if (state_q == gbdc_pkg::ST_FSTORE) axis_q <= axis_q + 2'd1;
      // restart the iteration count on entry to each loop
      if (state_q == gbdc_pkg::ST_FSQ || state_q == gbdc_pkg::ST_FDEV ||
          state_q == gbdc_pkg::ST_FOFF) begin
        step_q <= step_q + 5'd1;
      end else begin
        step_q <= '0;
      end
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken beat");

  a_loop_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbdc_pkg::ST_FSQ && $past(state_q) != gbdc_pkg::ST_FSQ) |-> step_q == 5'd0)
    else $error("sqrt loop entered with stale step count");

  a_short_run_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbdc_pkg::ST_CAL2 && !sts_i.run_full) |=> state_q == gbdc_pkg::ST_EMIT)
    else $error("unfinished calibration item did not go to emit");

  a_finish_ends_on_last_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbdc_pkg::ST_FSTORE && axis_q == gbdc_pkg::LastAxis)
      |=> state_q == gbdc_pkg::ST_EMIT)
    else $error("finish loop overran the last axis");

endmodule

`default_nettype wire

// ===== rtl/core/gyro_bias_deadband_calibrator_unit.sv =====
// ----------------------------------------------------------------------------
// gyro_bias_deadband_calibrator_unit
// Gyro bias calibration with standard deviation dead band, top level.
// ----------------------------------------------------------------------------
// Usage: in_ch carries one three-axis raw sample per beat with a command bit
// (calibrate or measure); out_ch returns one result beat per input beat, in
// order. cfg_ch writes rate_scale (0), calib_count (1) and threshold_multiple
// (2); it is always ready. It must be written only while the unit is idle;
// the block itself does not enforce this. A measure or calibrate beat passes
// through its MEAS or CAL states into the result register; the unit takes
// no new beat until the last one has been loaded there. The calibrate beat
// that completes a run adds a finish pass for each axis, built on the shared
// 32-step square root and the 32-step divider used twice per axis.
// Reset clears sums, offsets, dead bands, the calibrated flag and restores
// the config defaults. A result waits in its own register; the next sample is
// taken meanwhile and its result waits for that register to be emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module gyro_bias_deadband_calibrator_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gbdc_in_if.sink   in_ch,
  gbdc_out_if.source out_ch,
  gbdc_cfg_if.sink  cfg_ch
);

  gbdc_pkg::gbdc_cmd_t cmd;
  gbdc_pkg::gbdc_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  gbdc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_command_i (in_ch.command),
    .in_ready_o   (in_ch.ready),
    .out_valid_o  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  gbdc_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_ch.valid),
    .cfg_idx_i       (cfg_ch.index),
    .cfg_data_i      (cfg_ch.data),
    .raw_x_i         (in_ch.raw_x),
    .raw_y_i         (in_ch.raw_y),
    .raw_z_i         (in_ch.raw_z),
    .rate_x_o        (out_ch.rate_x),
    .rate_y_o        (out_ch.rate_y),
    .rate_z_o        (out_ch.rate_z),
    .is_calibrated_o (out_ch.is_calibrated),
    .calib_done_o    (out_ch.calib_done)
  );

endmodule

`default_nettype wire

// ===== tb/gbdc_checker.sv =====
// ----------------------------------------------------------------------------
// gbdc_checker
// Watches the sample, result and config channels of the calibrator, keeps
// its own copy of sums, offsets, dead bands and registers, predicts every
// result beat and compares it field by field against the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gbdc_checker
  import gbdc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  gbdc_in_if   in_mon,
  gbdc_out_if  out_mon,
  gbdc_cfg_if  cfg_mon,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic signed [RateW-1:0] rate_x;
    logic signed [RateW-1:0] rate_y;
    logic signed [RateW-1:0] rate_z;
    logic                    is_calibrated;
    logic                    calib_done;
  } rate_beat_t;

  rate_beat_t rate_queue[$];

  logic [15:0] scale_q;
  logic [7:0]  count_q;
  logic [7:0]  multiple_q;
  longint      axis_sum[3];
  longint      axis_sumsq[3];
  int          n_samples;
  longint      axis_offset[3];
  longint      axis_dev[3];
  logic        calibrated;

  int fails;
  assign fail_count_o = fails;
  assign pending_o    = rate_queue.size();

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q -= 1;
    return q;
  endfunction

  // Close the run: mean to offset, std dev to dead band, clear the sums.
  function automatic void close_run();
    longint n;
    longint v;
    n = n_samples;
    for (int i = 0; i < 3; i++) begin
      v = n * axis_sumsq[i] - axis_sum[i] * axis_sum[i];
      if (v < 0) v = 0;
      axis_offset[i] = floor_quot(axis_sum[i] * 16, n);
      axis_dev[i]    = longint'(root_floor(longint'(v) << 16) / longint'(n));
      axis_sum[i]    = 0;
      axis_sumsq[i]  = 0;
    end
    n_samples  = 0;
    calibrated = 1'b1;
  endfunction

  function automatic logic signed [RateW-1:0] axis_rate(logic signed [15:0] raw, int i);
    longint d;
    longint r;
    longint mag;
    d = longint'(raw) * 16;
    if (calibrated) d -= axis_offset[i];
    r   = (d * longint'(scale_q)) / 4096;
    mag = (r < 0) ? -r : r;
    if (multiple_q != 0 && ((mag >> 8) << 8) < axis_dev[i] * longint'(multiple_q)) r = 0;
    if (r > 1048575) r = 1048575;
    if (r < -1048576) r = -1048576;
    return r[RateW-1:0];
  endfunction

  function automatic rate_beat_t predict_rate(logic cmd, logic signed [15:0] rx,
                                              logic signed [15:0] ry,
                                              logic signed [15:0] rz);
    rate_beat_t b;
    longint raw[3];
    int target;
    b = '0;
    raw[0] = rx;
    raw[1] = ry;
    raw[2] = rz;
    if (cmd == CmdCalibrate) begin
      target = (count_q == 0) ? 1 : int'(count_q);
      for (int i = 0; i < 3; i++) begin
        axis_sum[i]   += raw[i];
        axis_sumsq[i] += raw[i] * raw[i];
      end
      n_samples++;
      if (n_samples >= target) begin
        close_run();
        b.calib_done = 1'b1;
      end
    end else begin
      b.rate_x = axis_rate(rx, 0);
      b.rate_y = axis_rate(ry, 1);
      b.rate_z = axis_rate(rz, 2);
    end
    b.is_calibrated = calibrated;
    return b;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rate_beat_t e;
    if (!rst_ni) begin
      scale_q    = RateScaleRst;
      count_q    = CalibCountRst;
      multiple_q = ThresholdRst;
      for (int i = 0; i < 3; i++) begin
        axis_sum[i]    = 0;
        axis_sumsq[i]  = 0;
        axis_offset[i] = 0;
        axis_dev[i]    = 0;
      end
      n_samples  = 0;
      calibrated = 1'b0;
      fails      = 0;
      rate_queue.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CfgRateScale:  scale_q    = cfg_mon.data;
          CfgCalibCount: count_q    = cfg_mon.data[7:0];
          CfgThreshold:  multiple_q = cfg_mon.data[7:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        rate_queue.push_back(predict_rate(in_mon.command, in_mon.raw_x,
                                          in_mon.raw_y, in_mon.raw_z));
      if (out_mon.valid && out_mon.ready) begin
        if (rate_queue.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got rate_x %0d",
                   $time, out_mon.rate_x);
          fails++;
        end else begin
          e = rate_queue.pop_front();
          check_field("rate_x", e.rate_x, out_mon.rate_x);
          check_field("rate_y", e.rate_y, out_mon.rate_y);
          check_field("rate_z", e.rate_z, out_mon.rate_z);
          check_field("is_calibrated", e.is_calibrated, out_mon.is_calibrated);
          check_field("calib_done", e.calib_done, out_mon.calib_done);
        end
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives calibration runs and measure samples into the gyro calibrator under
// changing scale, count and dead band settings, with bursty input and a
// stalling result side; the checker beside the block judges every beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int ItemTarget = 1650;
  localparam int CycleLimit = 3000000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   items_sent;
  int   burst_left;
  int   cycles;
  bit   hold_req;

  gbdc_in_if  in_ch ();
  gbdc_out_if out_ch ();
  gbdc_cfg_if cfg_ch ();

  gyro_bias_deadband_calibrator_unit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  gbdc_checker rate_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_mon     (cfg_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: the stall pattern is redrawn periodically from three modes;
  // a hold request drops ready for a long stretch.
  initial begin
    int mode;
    out_ch.ready = 1'b0;
    mode = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (cycles % 64 == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_sample(logic cmd, logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.raw_x   <= x;
    in_ch.raw_y   <= y;
    in_ch.raw_z   <= z;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    items_sent++;
  endtask

  // Wait out every result, then let the block settle before a config write.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic signed [15:0] near(int center, int spread);
    int v;
    v = center + $urandom_range(0, 2 * spread) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic send_noise();
    send_sample(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic calib_run(int n, int bias, int spread);
    for (int i = 0; i < n; i++)
      send_sample(gbdc_pkg::CmdCalibrate, near(bias, spread), near(-bias, spread),
                  near(bias / 2, spread));
  endtask

  task automatic measure_burst(int n, int bias, int spread);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) send_noise();
      else send_sample(gbdc_pkg::CmdMeasure, near(bias, spread), near(-bias, spread),
                       near(bias / 2, spread));
    end
  endtask

  initial begin
    int count;
    int bias;
    int spread;
    in_ch.valid    = 1'b0;
    in_ch.command  = gbdc_pkg::CmdMeasure;
    in_ch.raw_x    = '0;
    in_ch.raw_y    = '0;
    in_ch.raw_z    = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = gbdc_pkg::CfgRateScale;
    cfg_ch.data    = '0;
    hold_req       = 1'b0;
    items_sent     = 0;
    burst_left     = 0;
    cycles         = 0;
    rst_n          = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes uncalibrated at reset scale, then at full scale.
    send_sample(gbdc_pkg::CmdMeasure, 16'sh7FFF, -16'sd32768, 16'sd0);
    send_sample(gbdc_pkg::CmdMeasure, -16'sd1, 16'sd1, 16'sh7FFF);
    drain();
    write_reg(gbdc_pkg::CfgRateScale, 16'hFFFF);
    send_sample(gbdc_pkg::CmdMeasure, 16'sh7FFF, -16'sd32768, -16'sd1);
    drain();
    write_reg(gbdc_pkg::CfgRateScale, 16'h0000);
    write_reg(gbdc_pkg::CfgCalibCount, 16'h0001);
    send_sample(gbdc_pkg::CmdMeasure, 16'sh7FFF, 16'sh1234, -16'sd32768);
    // Single-sample run: zero deviation.
    send_sample(gbdc_pkg::CmdCalibrate, 16'sh7FFF, -16'sd32768, 16'sd5);
    drain();
    // Zero count acts as one; out-of-range index is ignored.
    write_reg(gbdc_pkg::CfgCalibCount, 16'hFF00);
    write_reg(2'd3, 16'hFFFF);
    write_reg(gbdc_pkg::CfgRateScale, 16'd4096);
    send_sample(gbdc_pkg::CmdCalibrate, -16'sd32768, 16'sh7FFF, -16'sd7);
    send_sample(gbdc_pkg::CmdMeasure, -16'sd32768, 16'sh7FFF, 16'sd0);
    drain();
    // Count lowered mid run: the next calibrate sample closes it.
    write_reg(gbdc_pkg::CfgCalibCount, 16'd4);
    send_sample(gbdc_pkg::CmdCalibrate, 16'sh7FFF, -16'sd32768, 16'sd100);
    send_sample(gbdc_pkg::CmdCalibrate, -16'sd32768, 16'sh7FFF, 16'sd90);
    send_sample(gbdc_pkg::CmdMeasure, 16'sd10, 16'sd10, 16'sd10);
    drain();
    write_reg(gbdc_pkg::CfgCalibCount, 16'd2);
    send_sample(gbdc_pkg::CmdCalibrate, 16'sd0, 16'sd0, 16'sd110);
    drain();
    // Widest dead band, then a modest one.
    write_reg(gbdc_pkg::CfgThreshold, 16'h00FF);
    write_reg(gbdc_pkg::CfgRateScale, 16'hFFFF);
    send_sample(gbdc_pkg::CmdMeasure, 16'sh7FFF, -16'sd32768, 16'sd100);
    send_sample(gbdc_pkg::CmdMeasure, 16'sd0, 16'sd0, 16'sd400);
    drain();
    write_reg(gbdc_pkg::CfgThreshold, 16'd1);
    send_sample(gbdc_pkg::CmdMeasure, 16'sh7FFF, -16'sd32768, 16'sd120);
    send_sample(gbdc_pkg::CmdMeasure, 16'sd5, -16'sd5, 16'sd100);
    // Long receiver hold while samples keep coming.
    hold_req = 1'b1;
    measure_burst(12, 0, 32767);
    drain();
    write_reg(gbdc_pkg::CfgCalibCount, 16'd255);
    calib_run(255, 300, 2000);
    measure_burst(10, 300, 500);
    drain();

    // Random phases.
    while (items_sent < ItemTarget) begin
      case ($urandom_range(0, 5))
        0:       write_reg(gbdc_pkg::CfgRateScale,
                           $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
        default: write_reg(gbdc_pkg::CfgRateScale, 16'($urandom));
      endcase
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 255) : $urandom_range(1, 20);
      write_reg(gbdc_pkg::CfgCalibCount, {8'($urandom_range(0, 255)), count[7:0]});
      case ($urandom_range(0, 3))
        0:       write_reg(gbdc_pkg::CfgThreshold, 16'h0000);
        1:       write_reg(gbdc_pkg::CfgThreshold, {8'($urandom_range(0, 255)), 8'hFF});
        default: write_reg(gbdc_pkg::CfgThreshold,
                           {8'($urandom_range(0, 255)), 8'($urandom_range(1, 6))});
      endcase
      for (int run = 0; run < $urandom_range(1, 3); run++) begin
        bias = $urandom_range(0, 8000) - 4000;
        case ($urandom_range(0, 3))
          0:       spread = 0;
          1:       spread = 3;
          2:       spread = 60;
          default: spread = 32767;
        endcase
        calib_run(count, bias, spread);
        measure_burst($urandom_range(5, 30), bias, $urandom_range(0, 1) ? 40 : 32767);
        if ($urandom_range(0, 15) == 0) hold_req = 1'b1;
        if ($urandom_range(0, 7) == 0) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
          burst_left = 0;
        end
      end
      drain();
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
